[rtl/ttgc_pkg.sv]
// Shared types, event codes, register indexes and reset values
// for the touch tap gesture classifier. No dependencies.

package ttgc_pkg;

   localparam int TimeWidth = 32;
   localparam int TicksWidth = 16;
   localparam int CountWidth = 4;
   localparam int EventWidth = 4;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth = 16;
   localparam int ReqDataWidth = 8;
   localparam int RspDataWidth = 16;

   localparam logic [EventWidth-1:0] EV_NONE        = 4'd0;
   localparam logic [EventWidth-1:0] EV_SIX_PLUS    = 4'd6;
   localparam logic [EventWidth-1:0] EV_TEN_PLUS    = 4'd7;
   localparam logic [EventWidth-1:0] EV_LONG        = 4'd8;
   localparam logic [EventWidth-1:0] EV_HIT         = 4'd9;
   localparam logic [EventWidth-1:0] EV_DRIBBLE_END = 4'd10;

   localparam logic [CountWidth-1:0] SIX_TAPS = 4'd6;

   localparam logic [CsrIndexWidth-1:0] REG_LONG_PRESS     = 3'd0;
   localparam logic [CsrIndexWidth-1:0] REG_TAP_WINDOW     = 3'd1;
   localparam logic [CsrIndexWidth-1:0] REG_RELEASE_GAP    = 3'd2;
   localparam logic [CsrIndexWidth-1:0] REG_DRIBBLE_TIMEOUT = 3'd3;
   localparam logic [CsrIndexWidth-1:0] REG_DRIBBLE_TAPS   = 3'd4;

   localparam logic [TicksWidth-1:0] LONG_PRESS_RESET      = 16'd800;
   localparam logic [TicksWidth-1:0] TAP_WINDOW_RESET      = 16'd1500;
   localparam logic [TicksWidth-1:0] RELEASE_GAP_RESET     = 16'd500;
   localparam logic [TicksWidth-1:0] DRIBBLE_TIMEOUT_RESET = 16'd3000;
   localparam logic [CountWidth-1:0] DRIBBLE_TAPS_RESET    = 4'd10;

   typedef struct packed {
      logic [TicksWidth-1:0] long_press_ticks;
      logic [TicksWidth-1:0] tap_window_ticks;
      logic [TicksWidth-1:0] release_gap_ticks;
      logic [TicksWidth-1:0] dribble_timeout_ticks;
      logic [CountWidth-1:0] dribble_tap_count;
   } cfg_type;

   typedef struct packed {
      logic anim_dribbling;
      logic menu_open;
      logic shake_trigger;
      logic touch_level;
   } req_type;

   typedef struct packed {
      logic                  dribble_on;
      logic                  long_hold_active;
      logic                  release_was_long;
      logic                  just_released;
      logic                  just_pressed;
      logic [EventWidth-1:0] event_code;
   } rsp_type;

endpackage

[rtl/ttgc_csr.sv]
// Configuration registers of the gesture classifier.
// Depends on ttgc_pkg.

module ttgc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ttgc_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [ttgc_pkg::CsrDataWidth-1:0]    csr_data,
   output ttgc_pkg::cfg_type                    cfg
);
   import ttgc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_LONG_PRESS:      cfg_in.long_press_ticks = csr_data[TicksWidth-1:0];
            REG_TAP_WINDOW:      cfg_in.tap_window_ticks = csr_data[TicksWidth-1:0];
            REG_RELEASE_GAP:     cfg_in.release_gap_ticks = csr_data[TicksWidth-1:0];
            REG_DRIBBLE_TIMEOUT: cfg_in.dribble_timeout_ticks = csr_data[TicksWidth-1:0];
            REG_DRIBBLE_TAPS:    cfg_in.dribble_tap_count = csr_data[CountWidth-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.long_press_ticks      <= LONG_PRESS_RESET;
         cfg_ff.tap_window_ticks      <= TAP_WINDOW_RESET;
         cfg_ff.release_gap_ticks     <= RELEASE_GAP_RESET;
         cfg_ff.dribble_timeout_ticks <= DRIBBLE_TIMEOUT_RESET;
         cfg_ff.dribble_tap_count     <= DRIBBLE_TAPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/ttgc_req_reg.sv]
// Input register slice: captures one tick sample per transfer.
// Depends on ttgc_pkg.

module ttgc_req_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ttgc_pkg::ReqDataWidth-1:0]  req_tdata,
   output logic                               item_valid,
   output ttgc_pkg::req_type                  item,
   input  logic                               item_take
);
   import ttgc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   assign req_tready = !valid_ff || item_take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !item_take);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_tdata[$bits(req_type)-1:0];
      end
   end

endmodule

[rtl/ttgc_core.sv]
// Gesture state and per-tick classification logic.
// Depends on ttgc_pkg.

module ttgc_core (
   input  logic               clock,
   input  logic               reset,
   input  ttgc_pkg::cfg_type  cfg,
   input  ttgc_pkg::req_type  item,
   input  logic               item_take,
   output ttgc_pkg::rsp_type  result
);
   import ttgc_pkg::*;

   logic [TimeWidth-1:0]  tick_ff, press_ff, release_ff, first_ff, last_hit_ff;
   logic [TimeWidth-1:0]  tick_in, press_in, release_in, first_in, last_hit_in;
   logic                  prev_ff, long_ff, dribble_ff;
   logic                  prev_in, long_in, dribble_in;
   logic [CountWidth-1:0] count_ff, count_in;

   logic                  now_touch, shake_hit, jp, jr, was_long, long_a, dribble_a;
   logic                  window_over, enter, gap_over, idle_over;
   logic [TimeWidth-1:0]  now, hold_time, last_a, last_b, first_a;
   logic [CountWidth-1:0] count_a, count_inc, count_b, count_c;
   logic [EventWidth-1:0] ev_a, ev_out;

   always_comb begin
      now       = tick_ff;
      now_touch = item.touch_level;
      jp        = now_touch && !prev_ff;
      jr        = !now_touch && prev_ff;
      press_in  = jp ? now : press_ff;
      release_in = jr ? now : release_ff;
      was_long  = jr && long_ff;
      long_a    = jr ? 1'b0 : long_ff;
      hold_time = now - press_in;
      long_in   = long_a || (now_touch && (hold_time >= TimeWidth'(cfg.long_press_ticks)));
      prev_in   = now_touch;

      shake_hit = item.shake_trigger && !item.menu_open;
      dribble_a = dribble_ff || (shake_hit && !item.anim_dribbling);
      last_a    = shake_hit ? now : last_hit_ff;
      count_a   = (shake_hit && !dribble_ff && !item.anim_dribbling) ? '0 : count_ff;
      ev_a      = EV_NONE;
      if (shake_hit) begin
         ev_a = (dribble_ff || item.anim_dribbling) ? EV_HIT : EV_TEN_PLUS;
      end

      last_b    = jp ? now : last_a;
      idle_over = (now - last_b) > TimeWidth'(cfg.dribble_timeout_ticks);

      first_a     = (jp && (count_ff == '0)) ? now : first_ff;
      count_inc   = count_ff + CountWidth'(1);
      window_over = (now - first_a) > TimeWidth'(cfg.tap_window_ticks);
      count_b     = count_ff;
      first_in    = first_ff;
      if (!dribble_a && jp) begin
         count_b  = window_over ? CountWidth'(1) : count_inc;
         first_in = window_over ? now : first_a;
      end
      enter    = jp && (count_b >= cfg.dribble_tap_count);
      gap_over = (now - release_in) > TimeWidth'(cfg.release_gap_ticks);

      count_c     = count_b;
      dribble_in  = dribble_a;
      last_hit_in = last_a;
      count_in    = count_a;
      ev_out      = ev_a;
      if (dribble_a) begin
         last_hit_in = last_b;
         if (jp) begin
            ev_out = EV_HIT;
         end
         if (idle_over) begin
            dribble_in = 1'b0;
            count_in   = '0;
            ev_out     = EV_DRIBBLE_END;
         end
      end else if (enter) begin
         dribble_in  = 1'b1;
         last_hit_in = now;
         count_in    = '0;
         ev_out      = EV_TEN_PLUS;
      end else begin
         if (long_in && (count_c != '0)) begin
            count_c = '0;
            ev_out  = EV_LONG;
         end
         if (!now_touch && (count_c != '0) && gap_over) begin
            ev_out  = (count_c >= SIX_TAPS) ? EV_SIX_PLUS : count_c;
            count_c = '0;
         end
         count_in = count_c;
      end

      tick_in = now + TimeWidth'(1);

      result.event_code       = ev_out;
      result.just_pressed     = jp;
      result.just_released    = jr;
      result.release_was_long = was_long;
      result.long_hold_active = long_in;
      result.dribble_on       = dribble_in || item.anim_dribbling;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff     <= '0;
         press_ff    <= '0;
         release_ff  <= '0;
         first_ff    <= '0;
         last_hit_ff <= '0;
         prev_ff     <= 1'b0;
         long_ff     <= 1'b0;
         dribble_ff  <= 1'b0;
         count_ff    <= '0;
      end else if (item_take) begin
         tick_ff     <= tick_in;
         press_ff    <= press_in;
         release_ff  <= release_in;
         first_ff    <= first_in;
         last_hit_ff <= last_hit_in;
         prev_ff     <= prev_in;
         long_ff     <= long_in;
         dribble_ff  <= dribble_in;
         count_ff    <= count_in;
      end
   end

endmodule

[rtl/ttgc_rsp_reg.sv]
// Result register: holds one classified tick until the transfer completes.
// Depends on ttgc_pkg.

module ttgc_rsp_reg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               load_valid,
   output logic                               load_ready,
   input  ttgc_pkg::rsp_type                  result,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ttgc_pkg::RspDataWidth-1:0]  rsp_tdata
);
   import ttgc_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type result_ff;

   assign load_ready = !valid_ff || rsp_tready;
   assign valid_in   = (load_valid && load_ready) || (valid_ff && !rsp_tready);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = RspDataWidth'(result_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         result_ff <= result;
      end
   end

endmodule

[rtl/touch_tap_gesture_classifier_top.sv]
// Touch tap gesture classifier: one tick sample in, one classified result out.
// Each tick passes the input register and then the result register before its result can transfer.
// Throughput one tick per cycle while rsp_tready is high; the per-tick state update is a single pass of compares.
// Synchronous active-high reset clears all gesture state and loads register defaults.
// Depends on ttgc_pkg, ttgc_csr, ttgc_req_reg, ttgc_core, ttgc_rsp_reg.

module touch_tap_gesture_classifier_top (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: touch_level, shake_trigger, menu_open, anim_dribbling, zero pad
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [ttgc_pkg::ReqDataWidth-1:0]   req_tdata,
   // rsp_tdata: event_code[3:0], just_pressed, just_released, release_was_long,
   //            long_hold_active, dribble_on, zero pad
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [ttgc_pkg::RspDataWidth-1:0]   rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ttgc_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [ttgc_pkg::CsrDataWidth-1:0]   csr_data
);
   import ttgc_pkg::*;

   cfg_type cfg;
   req_type item;
   rsp_type result;
   logic    item_valid;
   logic    load_ready;
   logic    item_take;

   assign item_take = item_valid && load_ready;

   ttgc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ttgc_req_reg u_req (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   ttgc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item      (item),
      .item_take (item_take),
      .result    (result)
   );

   ttgc_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load_valid (item_valid),
      .load_ready (load_ready),
      .result     (result),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

[rtl/ttgc_checker.sv]
// Port-level checks for the gesture classifier and the bind that attaches them.
// Depends on ttgc_pkg and touch_tap_gesture_classifier_top.

module ttgc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [ttgc_pkg::RspDataWidth-1:0]   rsp_tdata
);
   import ttgc_pkg::*;

   rsp_type rsp;
   assign rsp = rsp_tdata[$bits(rsp_type)-1:0];

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp.event_code <= EV_DRIBBLE_END)
      else $error("event code out of range");

   a_edges_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp.just_pressed && rsp.just_released))
      else $error("press and release in one tick");

   a_long_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.release_was_long |-> rsp.just_released && !rsp.long_hold_active)
      else $error("long release without release edge");

endmodule

bind touch_tap_gesture_classifier_top ttgc_checker u_ttgc_checker (.*);
